// ===== src/sfp_pkg.sv =====
// Shared types, constants and helpers for the STX/ETX frame parser.
// No dependencies; every other file in src except sfp_ram imports this package.
package sfp_pkg;

    localparam int BYTE_W        = 8;
    localparam int COUNT_OUT_W   = 6;
    localparam int INDEX_OUT_W   = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int DEFAULT_PARAM_DEPTH = 32;

    // Framing characters
    localparam logic [BYTE_W-1:0] LBRACK = 8'h5B;   // '['
    localparam logic [BYTE_W-1:0] RBRACK = 8'h5D;   // ']'

    // Register reset values
    localparam logic [BYTE_W-1:0] START_CODE_RST = 8'h02;
    localparam logic [BYTE_W-1:0] END_CODE_RST   = 8'h03;
    localparam logic [BYTE_W-1:0] DEV_ADDR_RST   = 8'h01;
    localparam logic [BYTE_W-1:0] BRO_ADDR_RST   = 8'hFF;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_CODE = 2'd0,
        CFG_END_CODE   = 2'd1,
        CFG_DEV_ADDR   = 2'd2,
        CFG_BRO_ADDR   = 2'd3
    } sfp_cfg_idx_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic clr_sum;      // clear running XOR
        logic xor_sum;      // fold rx byte into running XOR
        logic load_cmd;     // capture command, clear parameter count
        logic store_param;  // store rx byte in the parameter RAM if room
        logic load_chk_hi;  // capture high checksum nibble
        logic emit_start;   // rewind the readout index
        logic rd_issue;     // read next stored parameter for output
        logic emit_none;    // load the single no-parameter result
    } sfp_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic zero_byte;
        logic hit_start;
        logic hit_dev;
        logic hit_bro;
        logic hit_lbrack;
        logic hit_rbrack;
        logic sum_ok;
        logic hit_end;
        logic count_zero;
        logic rd_last;
        logic out_free;
    } sfp_sts_t;

    // ASCII hex digit to nibble; anything else decodes as zero
    function automatic logic [3:0] hex_nibble(input logic [BYTE_W-1:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
            n = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46)
            n = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66)
            n = 4'(c - 8'h57);
        return n;
    endfunction

endpackage

// ===== src/sfp_if.sv =====
// Valid/ready stream interfaces for the received bytes and the results.
// Depends on sfp_pkg for field widths.
interface sfp_rx_if import sfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfp_res_if import sfp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [BYTE_W-1:0]      command;
    logic [COUNT_OUT_W-1:0] param_count;
    logic [INDEX_OUT_W-1:0] param_index;
    logic [BYTE_W-1:0]      param_byte;
    logic                   has_param;
    logic                   last;

    modport source (output valid, output command, output param_count, output param_index,
                    output param_byte, output has_param, output last, input ready);
    modport sink   (input valid, input command, input param_count, input param_index,
                    input param_byte, input has_param, input last, output ready);
endinterface

// ===== src/stx_etx_frame_parser.sv =====
// STX/ETX frame parser with XOR checksum: top level joining controller and datapath.
// Depends on sfp_pkg, sfp_if, sfp_ram, sfp_datapath and sfp_ctrl.
//
// Usage:
//   rx carries one received byte per transaction; a zero byte means no data and
//   returns the parser to hunting for the start code. res carries the results of
//   a good frame: one per stored parameter byte, or one without a parameter.
//   Configuration (start code, end code, device and broadcast address) is written
//   through cfg_wr_en / cfg_index / cfg_wdata while the block is idle.
// Throughput and readout:
//   While parsing, one byte is taken every cycle. After a good end code rx stalls
//   for the readout: each stored parameter is read from the registered RAM into
//   the result register, or the no-parameter result is loaded there directly.
//   The next registered RAM read is issued only after the previous one has
//   reached the output register. rx reopens in the cycle after the last read is
//   issued, while the last result may still wait in the output register.
// Reset:
//   rst_n clears the state machine, counters and output valid and loads the
//   register defaults. The parameter RAM is not cleared and needs no sweep.
// Stalls:
//   A low res.ready holds the result register; readout pauses until it drains.
module stx_etx_frame_parser import sfp_pkg::*; #(
    parameter int PARAM_DEPTH = DEFAULT_PARAM_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_wdata,
    sfp_rx_if.sink               rx,
    sfp_res_if.source            res
);

    sfp_cmd_t cmd;
    sfp_sts_t sts;

    // Frame state machine
    sfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_ready (rx.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Compares, checksum, parameter store and result register
    sfp_datapath #(
        .PARAM_DEPTH (PARAM_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .rx_byte         (rx.rx_byte),
        .cmd             (cmd),
        .sts             (sts),
        .res_ready       (res.ready),
        .res_valid       (res.valid),
        .res_command     (res.command),
        .res_param_count (res.param_count),
        .res_param_index (res.param_index),
        .res_param_byte  (res.param_byte),
        .res_has_param   (res.has_param),
        .res_last        (res.last)
    );

endmodule

// ===== src/sfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/sfp_datapath.sv =====
// Datapath: config registers, byte compares, running XOR, parameter RAM,
// readout pipeline and result register. Depends on sfp_pkg and sfp_ram.
module sfp_datapath import sfp_pkg::*; #(
    parameter int PARAM_DEPTH = DEFAULT_PARAM_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration writes
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [BYTE_W-1:0]      cfg_wdata,
    // input byte
    input  logic [BYTE_W-1:0]      rx_byte,
    // controller link
    input  sfp_cmd_t               cmd,
    output sfp_sts_t               sts,
    // result channel
    input  logic                   res_ready,
    output logic                   res_valid,
    output logic [BYTE_W-1:0]      res_command,
    output logic [COUNT_OUT_W-1:0] res_param_count,
    output logic [INDEX_OUT_W-1:0] res_param_index,
    output logic [BYTE_W-1:0]      res_param_byte,
    output logic                   res_has_param,
    output logic                   res_last
);

    localparam int ADDR_W = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;
    localparam int CNT_W  = $clog2(PARAM_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PARAM_DEPTH);

    // Configuration registers
    logic [BYTE_W-1:0] start_code_reg, end_code_reg, dev_addr_reg, bro_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg <= START_CODE_RST;
            end_code_reg   <= END_CODE_RST;
            dev_addr_reg   <= DEV_ADDR_RST;
            bro_addr_reg   <= BRO_ADDR_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (sfp_cfg_idx_t'(cfg_index))
                CFG_START_CODE: start_code_reg <= cfg_wdata;
                CFG_END_CODE:   end_code_reg   <= cfg_wdata;
                CFG_DEV_ADDR:   dev_addr_reg   <= cfg_wdata;
                CFG_BRO_ADDR:   bro_addr_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Frame state
    logic [BYTE_W-1:0] sum_calc_reg, sum_calc_next;
    logic [3:0]        chk_hi_reg, chk_hi_next;
    logic [BYTE_W-1:0] held_cmd_reg, held_cmd_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]  rd_idx_inc;
    logic [3:0]        rx_nibble;
    logic              count_full;
    logic              ram_we;

    assign rx_nibble  = hex_nibble(rx_byte);
    assign count_full = (count_reg == CNT_FULL);
    assign ram_we     = cmd.store_param && !count_full;
    assign rd_idx_inc = rd_idx_reg + CNT_W'(1);

    always_comb
    begin
        sum_calc_next = sum_calc_reg;
        chk_hi_next   = chk_hi_reg;
        held_cmd_next = held_cmd_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        if (cmd.clr_sum)
            sum_calc_next = '0;
        else if (cmd.xor_sum)
            sum_calc_next = sum_calc_reg ^ rx_byte;
        if (cmd.load_chk_hi)
            chk_hi_next = rx_nibble;
        if (cmd.load_cmd)
        begin
            held_cmd_next = rx_byte;
            count_next    = '0;
        end
        else if (ram_we)
            count_next = count_reg + CNT_W'(1);
        if (cmd.emit_start)
            rd_idx_next = '0;
        else if (cmd.rd_issue)
            rd_idx_next = rd_idx_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_calc_reg <= '0;
            chk_hi_reg   <= '0;
            held_cmd_reg <= '0;
            count_reg    <= '0;
            rd_idx_reg   <= '0;
        end
        else
        begin
            sum_calc_reg <= sum_calc_next;
            chk_hi_reg   <= chk_hi_next;
            held_cmd_reg <= held_cmd_next;
            count_reg    <= count_next;
            rd_idx_reg   <= rd_idx_next;
        end
    end

    // Parameter store
    logic [BYTE_W-1:0] ram_rdata;

    sfp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PARAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (rx_byte),
        .re    (cmd.rd_issue),
        .raddr (rd_idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Read-in-flight stage: index and last flag travel with the RAM read
    logic             pend_reg;
    logic [CNT_W-1:0] pend_idx_reg;
    logic             pend_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else
            pend_reg <= cmd.rd_issue;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            pend_idx_reg  <= rd_idx_reg;
            pend_last_reg <= (rd_idx_inc == count_reg);
        end
    end

    // Result register
    logic                   out_valid_reg;
    logic [BYTE_W-1:0]      out_cmd_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic [INDEX_OUT_W-1:0] out_index_reg;
    logic [BYTE_W-1:0]      out_byte_reg;
    logic                   out_has_reg;
    logic                   out_last_reg;
    logic [COUNT_OUT_W-1:0] pend_idx_wide;

    assign pend_idx_wide = COUNT_OUT_W'(pend_idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pend_reg || cmd.emit_none)
            out_valid_reg <= 1'b1;
        else if (res_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            out_cmd_reg   <= held_cmd_reg;
            out_count_reg <= COUNT_OUT_W'(count_reg);
            out_index_reg <= pend_idx_wide[INDEX_OUT_W-1:0];
            out_byte_reg  <= ram_rdata;
            out_has_reg   <= 1'b1;
            out_last_reg  <= pend_last_reg;
        end
        else if (cmd.emit_none)
        begin
            out_cmd_reg   <= held_cmd_reg;
            out_count_reg <= '0;
            out_index_reg <= '0;
            out_byte_reg  <= '0;
            out_has_reg   <= 1'b0;
            out_last_reg  <= 1'b1;
        end
    end

    assign res_valid       = out_valid_reg;
    assign res_command     = out_cmd_reg;
    assign res_param_count = out_count_reg;
    assign res_param_index = out_index_reg;
    assign res_param_byte  = out_byte_reg;
    assign res_has_param   = out_has_reg;
    assign res_last        = out_last_reg;

    // Status to controller
    always_comb
    begin
        sts.zero_byte  = (rx_byte == '0);
        sts.hit_start  = (rx_byte == start_code_reg);
        sts.hit_dev    = (rx_byte == dev_addr_reg);
        sts.hit_bro    = (rx_byte == bro_addr_reg);
        sts.hit_lbrack = (rx_byte == LBRACK);
        sts.hit_rbrack = (rx_byte == RBRACK);
        sts.sum_ok     = ({chk_hi_reg, rx_nibble} == sum_calc_reg);
        sts.hit_end    = (rx_byte == end_code_reg);
        sts.count_zero = (count_reg == '0);
        sts.rd_last    = (rd_idx_inc == count_reg);
        sts.out_free   = !pend_reg && (!out_valid_reg || res_ready);
    end

endmodule

// ===== src/sfp_ctrl.sv =====
// Controller: one-hot frame parsing state machine plus result readout sequencing.
// Depends on sfp_pkg for the command and status structs.
module sfp_ctrl import sfp_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     rx_valid,
    output logic     rx_ready,
    input  sfp_sts_t sts,
    output sfp_cmd_t cmd
);

    typedef enum logic [10:0] {
        ST_HUNT   = 11'b000_0000_0001,
        ST_DEV    = 11'b000_0000_0010,
        ST_BRO    = 11'b000_0000_0100,
        ST_CMD    = 11'b000_0000_1000,
        ST_OPT    = 11'b000_0001_0000,
        ST_PARAMS = 11'b000_0010_0000,
        ST_CHK_HI = 11'b000_0100_0000,
        ST_CHK_LO = 11'b000_1000_0000,
        ST_END    = 11'b001_0000_0000,
        ST_ERROR  = 11'b010_0000_0000,
        ST_EMIT   = 11'b100_0000_0000
    } sfp_state_t;

    sfp_state_t state_reg, state_next;
    logic       rx_fire;

    // Input stalls only in the emit state, while the results are read out
    assign rx_ready = (state_reg != ST_EMIT);
    assign rx_fire  = rx_valid && rx_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        priority if (state_reg == ST_EMIT)
        begin
            if (sts.out_free)
            begin
                if (sts.count_zero)
                begin
                    cmd.emit_none = 1'b1;
                    state_next    = ST_HUNT;
                end
                else
                begin
                    cmd.rd_issue = 1'b1;
                    if (sts.rd_last)
                        state_next = ST_HUNT;
                end
            end
        end
        else if (rx_fire && sts.zero_byte)
            state_next = ST_HUNT;
        else if (rx_fire)
        begin
            unique case (state_reg)
                ST_HUNT:
                begin
                    if (sts.hit_start)
                    begin
                        cmd.clr_sum = 1'b1;
                        state_next  = ST_DEV;
                    end
                end
                ST_DEV:
                begin
                    cmd.xor_sum = sts.hit_dev;
                    state_next  = sts.hit_dev ? ST_BRO : ST_ERROR;
                end
                ST_BRO:
                begin
                    cmd.xor_sum = sts.hit_bro;
                    state_next  = sts.hit_bro ? ST_CMD : ST_ERROR;
                end
                ST_CMD:
                begin
                    cmd.load_cmd = 1'b1;
                    cmd.xor_sum  = 1'b1;
                    state_next   = ST_OPT;
                end
                ST_OPT:
                begin
                    // no bracket: this byte is already the high checksum digit
                    if (sts.hit_lbrack)
                    begin
                        cmd.xor_sum = 1'b1;
                        state_next  = ST_PARAMS;
                    end
                    else
                    begin
                        cmd.load_chk_hi = 1'b1;
                        state_next      = ST_CHK_LO;
                    end
                end
                ST_PARAMS:
                begin
                    cmd.xor_sum = 1'b1;
                    if (sts.hit_rbrack)
                        state_next = ST_CHK_HI;
                    else
                        cmd.store_param = 1'b1;
                end
                ST_CHK_HI:
                begin
                    cmd.load_chk_hi = 1'b1;
                    state_next      = ST_CHK_LO;
                end
                ST_CHK_LO:
                    state_next = sts.sum_ok ? ST_END : ST_ERROR;
                ST_END:
                begin
                    if (sts.hit_end)
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = ST_EMIT;
                    end
                    else
                        state_next = ST_ERROR;
                end
                default: ;  // error: hold until a zero byte
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_HUNT;
        else
            state_reg <= state_next;
    end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for stx_etx_frame_parser: directed and random byte streams,
// results checked in order against a cycle-free frame predictor.
// Depends on sfp_pkg, sfp_if and the parser RTL in src.
module tb_top import sfp_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 10;
    localparam int STORE_DEPTH  = DEFAULT_PARAM_DEPTH;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_PRINTS   = 40;

    // Parser phases as tracked by the predictor
    typedef enum logic [3:0] {
        PS_HUNT, PS_DEV, PS_BRO, PS_CMD, PS_OPT, PS_PARAMS, PS_CHK, PS_END, PS_ERROR
    } parse_phase_t;

    // Ways a generated frame can be broken
    typedef enum int {
        FLAW_NONE, FLAW_DEV, FLAW_BRO, FLAW_SUM, FLAW_END, FLAW_CUT
    } frame_flaw_t;

    typedef struct {
        logic [BYTE_W-1:0]      command;
        logic [COUNT_OUT_W-1:0] param_count;
        logic [INDEX_OUT_W-1:0] param_index;
        logic [BYTE_W-1:0]      param_byte;
        logic                   has_param;
        logic                   last;
    } frame_result_t;

    // Clock, reset and block inputs, all known from time zero
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    sfp_cfg_idx_t         cfg_index = CFG_START_CODE;
    logic [BYTE_W-1:0]    cfg_wdata = '0;
    logic                 drv_valid = 1'b0;
    logic [BYTE_W-1:0]    drv_byte  = '0;
    logic                 mon_ready = 1'b0;

    int src_idle_pct  = 13;
    int sink_idle_pct = 76;
    int err_count     = 0;
    int res_seen      = 0;
    int cycle_count   = 0;

    logic [BYTE_W-1:0] pending_bytes[$];
    logic [BYTE_W-1:0] frame_params[$];
    frame_result_t     exp_results[$];
    frame_result_t     want;

    // Predictor state and register mirror
    parse_phase_t      ps;
    logic [BYTE_W-1:0] cfg_start, cfg_end, cfg_dev, cfg_bro;
    logic [BYTE_W-1:0] run_xor, got_sum, cur_cmd;
    logic              hi_seen;
    int                n_stored;
    logic [BYTE_W-1:0] store [STORE_DEPTH];

    sfp_rx_if  rx_ch();
    sfp_res_if res_ch();

    assign rx_ch.valid   = drv_valid;
    assign rx_ch.rx_byte = drv_byte;
    assign res_ch.ready  = mon_ready;

    stx_etx_frame_parser #(.PARAM_DEPTH(STORE_DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rx        (rx_ch),
        .res       (res_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Mismatch reporting
    task automatic log_mismatch(input string msg);
        if (err_count < MAX_PRINTS)
            $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic compare_field(input string name, input int unsigned got,
                                 input int unsigned exp_val);
        if (got != exp_val)
            log_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                   res_seen, name, got, exp_val));
    endtask

    function automatic bit is_hex(input logic [BYTE_W-1:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    // Letters share the low nibble pattern: 'A'/'a' -> 1, plus 9 gives 10
    function automatic logic [3:0] digit_value(input logic [BYTE_W-1:0] c);
        if (!is_hex(c))
            return 4'h0;
        if (c <= "9")
            return c[3:0];
        return c[3:0] + 4'd9;
    endfunction

    // Predictor: advance the frame parser by one byte, queue any results
    task automatic parse_byte(input logic [BYTE_W-1:0] b);
        frame_result_t r;
        if (b == 8'h00)
        begin
            ps = PS_HUNT;
        end
        else
        begin
            unique case (ps)
                PS_HUNT:
                    if (b == cfg_start)
                    begin
                        run_xor = '0;
                        ps = PS_DEV;
                    end
                PS_DEV:
                    if (b == cfg_dev)
                    begin
                        run_xor ^= b;
                        ps = PS_BRO;
                    end
                    else
                    begin
                        ps = PS_ERROR;
                    end
                PS_BRO:
                    if (b == cfg_bro)
                    begin
                        run_xor ^= b;
                        ps = PS_CMD;
                    end
                    else
                    begin
                        ps = PS_ERROR;
                    end
                PS_CMD:
                begin
                    cur_cmd  = b;
                    got_sum  = '0;
                    hi_seen  = 1'b0;
                    run_xor ^= b;
                    n_stored = 0;
                    ps = PS_OPT;
                end
                PS_OPT:
                    if (b == LBRACK)
                    begin
                        run_xor ^= b;
                        ps = PS_PARAMS;
                    end
                    else
                    begin
                        // no parameter list: this is the high checksum digit
                        hi_seen = 1'b1;
                        got_sum = {digit_value(b), 4'h0};
                        ps = PS_CHK;
                    end
                PS_PARAMS:
                begin
                    run_xor ^= b;
                    if (b == RBRACK)
                    begin
                        ps = PS_CHK;
                    end
                    else if (n_stored < STORE_DEPTH)
                    begin
                        store[n_stored] = b;
                        n_stored++;
                    end
                end
                PS_CHK:
                    if (!hi_seen)
                    begin
                        got_sum = {digit_value(b), 4'h0};
                        hi_seen = 1'b1;
                    end
                    else
                    begin
                        got_sum = {got_sum[7:4], digit_value(b)};
                        ps = (got_sum == run_xor) ? PS_END : PS_ERROR;
                    end
                PS_END:
                    if (b == cfg_end)
                    begin
                        ps = PS_HUNT;
                        r.command     = cur_cmd;
                        r.param_count = COUNT_OUT_W'(n_stored);
                        if (n_stored == 0)
                        begin
                            r.param_index = '0;
                            r.param_byte  = '0;
                            r.has_param   = 1'b0;
                            r.last        = 1'b1;
                            exp_results.push_back(r);
                        end
                        for (int i = 0; i < n_stored; i++)
                        begin
                            r.param_index = INDEX_OUT_W'(i);
                            r.param_byte  = store[i];
                            r.has_param   = 1'b1;
                            r.last        = (i + 1 == n_stored);
                            exp_results.push_back(r);
                        end
                    end
                    else
                    begin
                        ps = PS_ERROR;
                    end
                default: ;  // error: wait for a zero byte
            endcase
        end
    endtask

    // Driver: one rx transaction per accepted byte, random source gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (drv_valid && rx_ch.ready)
                parse_byte(drv_byte);
            if (!drv_valid || rx_ch.ready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    drv_valid <= 1'b1;
                    drv_byte  <= pending_bytes.pop_front();
                end
                else
                begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid && mon_ready)
            begin
                if (exp_results.size() == 0)
                begin
                    log_mismatch($sformatf("result %0d arrived with none expected", res_seen));
                end
                else
                begin
                    want = exp_results.pop_front();
                    compare_field("command",     res_ch.command,     want.command);
                    compare_field("param_count", res_ch.param_count, want.param_count);
                    compare_field("param_index", res_ch.param_index, want.param_index);
                    compare_field("param_byte",  res_ch.param_byte,  want.param_byte);
                    compare_field("has_param",   res_ch.has_param,   want.has_param);
                    compare_field("last",        res_ch.last,        want.last);
                end
                res_seen++;
            end
            mon_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ERROR: timeout, %0d results still expected", exp_results.size());
            $display("FAIL stx_etx_frame_parser");
            $finish;
        end
    end

    // Stimulus helpers
    function automatic logic [BYTE_W-1:0] rand_param();
        logic [BYTE_W-1:0] c;
        c = BYTE_W'($urandom_range(1, 255));
        while (c == RBRACK)
            c = BYTE_W'($urandom_range(1, 255));
        return c;
    endfunction

    // ASCII digit for a checksum nibble; a zero nibble may go out as a non-hex byte
    function automatic logic [BYTE_W-1:0] sum_digit(input logic [3:0] nib, input bit lower);
        logic [BYTE_W-1:0] c;
        if (nib == 4'h0 && $urandom_range(3) == 0)
        begin
            c = BYTE_W'($urandom_range(1, 255));
            while (is_hex(c) || c == LBRACK)
                c = BYTE_W'($urandom_range(1, 255));
        end
        else if (nib < 4'd10)
        begin
            c = "0" + BYTE_W'(nib);
        end
        else if (lower)
        begin
            c = "a" + BYTE_W'(nib) - 8'd10;
        end
        else
        begin
            c = "A" + BYTE_W'(nib) - 8'd10;
        end
        return c;
    endfunction

    task automatic fill_params(input int n);
        frame_params.delete();
        repeat (n) frame_params.push_back(rand_param());
    endtask

    // Queue one frame built from the current registers and frame_params
    task automatic add_frame(input logic [BYTE_W-1:0] cmd, input bit bracket,
                             input frame_flaw_t flaw);
        logic [BYTE_W-1:0] seq[$];
        logic [BYTE_W-1:0] sum, dev_b, bro_b, end_b;
        bit                lower;
        int                cut;
        lower = 1'($urandom_range(1));
        dev_b = cfg_dev;
        bro_b = cfg_bro;
        end_b = cfg_end;
        if (flaw == FLAW_DEV) dev_b = cfg_dev ^ BYTE_W'($urandom_range(1, 255));
        if (flaw == FLAW_BRO) bro_b = cfg_bro ^ BYTE_W'($urandom_range(1, 255));
        if (flaw == FLAW_END) end_b = cfg_end ^ BYTE_W'($urandom_range(1, 255));
        sum = cfg_dev ^ cfg_bro ^ cmd;
        seq.push_back(cfg_start);
        seq.push_back(dev_b);
        seq.push_back(bro_b);
        seq.push_back(cmd);
        if (bracket)
        begin
            seq.push_back(LBRACK);
            sum ^= LBRACK;
            foreach (frame_params[i])
            begin
                seq.push_back(frame_params[i]);
                sum ^= frame_params[i];
            end
            seq.push_back(RBRACK);
            sum ^= RBRACK;
        end
        if (flaw == FLAW_SUM) sum ^= BYTE_W'($urandom_range(1, 255));
        seq.push_back(sum_digit(sum[7:4], lower));
        seq.push_back(sum_digit(sum[3:0], lower));
        seq.push_back(end_b);
        if (flaw == FLAW_CUT)
        begin
            cut = $urandom_range(1, seq.size() - 1);
            while (seq.size() > cut)
                void'(seq.pop_back());
        end
        foreach (seq[i]) pending_bytes.push_back(seq[i]);
        // broken frames: maybe a byte that the error state ignores, then recover
        if (flaw != FLAW_NONE)
        begin
            if ($urandom_range(1))
                pending_bytes.push_back(BYTE_W'($urandom_range(1, 255)));
            pending_bytes.push_back(8'h00);
        end
    endtask

    // Mostly good frames with random content, some broken frames and line noise
    task automatic random_traffic(input int n_bytes);
        int goal, r, n;
        frame_flaw_t flaw;
        @(negedge clk);
        goal = pending_bytes.size() + n_bytes;
        while (pending_bytes.size() < goal)
        begin
            r = $urandom_range(99);
            if (r < 88)
            begin
                n = $urandom_range(99);
                if (n < 80)      fill_params($urandom_range(0, 4));
                else if (n < 97) fill_params($urandom_range(5, 12));
                else             fill_params($urandom_range(28, 40));
                flaw = (r < 70) ? FLAW_NONE : frame_flaw_t'($urandom_range(1, 5));
                add_frame(BYTE_W'($urandom_range(1, 255)),
                          frame_params.size() != 0 || $urandom_range(1) == 1, flaw);
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    if ($urandom_range(3) == 0) pending_bytes.push_back(8'h00);
                    else pending_bytes.push_back(BYTE_W'($urandom_range(1, 255)));
                end
            end
        end
    endtask

    // Wait until every byte went in and every expected result came out
    task automatic wait_drained();
        @(negedge clk);
        while (pending_bytes.size() != 0 || drv_valid || exp_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input sfp_cfg_idx_t idx, input logic [BYTE_W-1:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        unique case (idx)
            CFG_START_CODE: cfg_start = v;
            CFG_END_CODE:   cfg_end   = v;
            CFG_DEV_ADDR:   cfg_dev   = v;
            default:        cfg_bro   = v;
        endcase
    endtask

    task automatic set_config(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                              input logic [BYTE_W-1:0] d, input logic [BYTE_W-1:0] b);
        write_reg(CFG_START_CODE, s);
        write_reg(CFG_END_CODE, e);
        write_reg(CFG_DEV_ADDR, d);
        write_reg(CFG_BRO_ADDR, b);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Main sequence
    initial
    begin
        ps        = PS_HUNT;
        cfg_start = START_CODE_RST;
        cfg_end   = END_CODE_RST;
        cfg_dev   = DEV_ADDR_RST;
        cfg_bro   = BRO_ADDR_RST;
        run_xor   = '0;
        got_sum   = '0;
        cur_cmd   = '0;
        hi_seen   = 1'b0;
        n_stored  = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero byte, hunt noise, bare frame, extreme parameters, bad address
        @(negedge clk);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(cfg_end);
        frame_params.delete();
        add_frame(8'h01, 1'b0, FLAW_NONE);
        frame_params = {8'h80, 8'h7F};
        add_frame(8'hFF, 1'b1, FLAW_NONE);
        pending_bytes.push_back(cfg_start);
        pending_bytes.push_back(8'h55);
        pending_bytes.push_back(8'h41);
        pending_bytes.push_back(8'h00);

        random_traffic(40);
        wait_drained();

        // High extremes on the codes, plus a frame that overflows the store
        set_config(8'hFF, 8'h01, 8'hFE, 8'h01);
        random_traffic(50);
        fill_params(36);
        add_frame(BYTE_W'($urandom_range(1, 255)), 1'b1, FLAW_NONE);
        wait_drained();

        // All zero: no code or address can ever match
        src_idle_pct  = 76;
        sink_idle_pct = 13;
        set_config(8'h00, 8'h00, 8'h00, 8'h00);
        random_traffic(20);
        wait_drained();

        set_config(8'h01, 8'hFF, 8'hFF, 8'h01);
        random_traffic(60);
        wait_drained();

        // No idling; a full store and codes colliding with the brackets
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        set_config(BYTE_W'($urandom_range(1, 255)), BYTE_W'($urandom_range(1, 255)),
                   BYTE_W'($urandom_range(1, 255)), BYTE_W'($urandom_range(1, 255)));
        random_traffic(60);
        @(negedge clk);
        fill_params(STORE_DEPTH);
        add_frame(BYTE_W'($urandom_range(1, 255)), 1'b1, FLAW_NONE);
        wait_drained();

        set_config(LBRACK, RBRACK, LBRACK, RBRACK);
        random_traffic(60);
        wait_drained();

        if (err_count == 0)
            $display("PASS stx_etx_frame_parser");
        else
            $display("FAIL stx_etx_frame_parser");
        $finish;
    end

endmodule
